FILE: hw/rtl/rmq_pkg.sv
// shared types for the rotation matrix to quaternion converter
// no dependencies; used by rotation_matrix_to_quaternion and its checker
package rmq_pkg;

	// quaternion component slots in output order
	typedef enum logic [1:0] {
		SLOT_W = 2'd0,
		SLOT_X = 2'd1,
		SLOT_Y = 2'd2,
		SLOT_Z = 2'd3
	} slot_t;

	// tuser width on the result side (degenerate flag)
	localparam int OUT_USER_W = 1;

endpackage

FILE: hw/rtl/rotation_matrix_to_quaternion.sv
// rotation matrix to quaternion converter, Shepperd's method, fixed point pipeline
// depends on rmq_pkg
//
// usage:
//   s_axis carries one 3x3 matrix per item, nine signed elements in tdata,
//   m00 in the lowest bits, row then column. m_axis returns one quaternion per
//   item: w, x, y, z in tdata from the lowest bits up, degenerate flag in tuser.
//   the pipeline registers the input, each square root stage, the divider
//   setup, each divider stage and the output; RTW is the root width, NW
//   the quotient width. the depth comes from the square root (one root bit
//   per stage) and three parallel dividers (one quotient bit per stage).
//   one item per cycle is taken unless stalled; no state is kept between items.
//   reset empties the pipeline; the first item can enter right after.
//   when the receiver stalls with a result waiting, the whole pipeline holds
//   and s_axis_tready drops; while the output stage is empty or being taken,
//   s_axis_tready stays high.
//   degenerate is raised with all components zero when the root is zero.
module rotation_matrix_to_quaternion #(
	parameter int DATA_WIDTH    = 16,
	parameter int FRACTION_BITS = 14
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// m00 m01 m02 m10 m11 m12 m20 m21 m22, zero padded to bytes
	input  logic [((9*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// quat_w quat_x quat_y quat_z, zero padded to bytes
	output logic [((4*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	// degenerate
	output logic [rmq_pkg::OUT_USER_W-1:0] m_axis_tuser
);

	localparam int DW   = DATA_WIDTH;
	localparam int FB   = FRACTION_BITS;
	localparam int OUT_W = ((4*DW+7)/8)*8;
	localparam int RW   = DW + 2;
	localparam int RTW  = (RW + FB + 1) / 2;
	localparam int VW   = 2 * RTW;
	localparam int MW   = DW + 1;
	localparam int NW   = ((MW + FB > RTW) ? MW + FB : RTW) + 1;
	localparam int SW   = RTW + 1;
	localparam int XW   = DW + 3;

	typedef struct packed {
		logic [VW-1:0]          v;
		logic [RTW+1:0]         rem;
		logic [RTW-1:0]         root;
		logic [1:0]             dslot;
		logic [2:0][DW:0]       d;
	} sq_t;

	typedef struct packed {
		logic [2:0][NW-1:0] nq;
		logic [2:0][SW-1:0] rem;
		logic [2:0]         neg;
		logic [RTW-1:0]     root;
		logic [1:0]         dslot;
	} dv_t;

	logic en;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// ---------------- stage 1: trace, pivot choice, radicand, differences
	logic signed [DW-1:0] m [0:8];
	logic signed [XW-1:0] e [0:8];
	logic signed [XW-1:0] trace, rad;
	logic [1:0] piv;
	logic [1:0] dslot;
	logic signed [DW:0] d0, d1, d2;
	sq_t sq_in;

	always_comb begin
		for (int n = 0; n < 9; n++) begin
			m[n] = $signed(s_axis_tdata[n*DW +: DW]);
			e[n] = XW'(m[n]);
		end
	end

	always_comb begin
		logic signed [XW-1:0] one;
		one   = XW'(1) <<< FB;
		trace = e[0] + e[4] + e[8];
		piv   = 2'd0;
		if (m[4] > m[0])
			piv = 2'd1;
		if ((piv == 2'd0 && m[8] > m[0]) || (piv == 2'd1 && m[8] > m[4]))
			piv = 2'd2;
		rad   = one + trace;
		dslot = rmq_pkg::SLOT_W;
		d0    = (DW+1)'(e[7] - e[5]);
		d1    = (DW+1)'(e[2] - e[6]);
		d2    = (DW+1)'(e[3] - e[1]);
		if (!(trace > 0)) begin
			unique case (piv)
				2'd0: begin
					rad   = one + e[0] - e[4] - e[8];
					dslot = rmq_pkg::SLOT_X;
					d0    = (DW+1)'(e[7] - e[5]);
					d1    = (DW+1)'(e[3] + e[1]);
					d2    = (DW+1)'(e[6] + e[2]);
				end
				2'd1: begin
					rad   = one + e[4] - e[8] - e[0];
					dslot = rmq_pkg::SLOT_Y;
					d0    = (DW+1)'(e[2] - e[6]);
					d1    = (DW+1)'(e[1] + e[3]);
					d2    = (DW+1)'(e[7] + e[5]);
				end
				default: begin
					rad   = one + e[8] - e[0] - e[4];
					dslot = rmq_pkg::SLOT_Z;
					d0    = (DW+1)'(e[3] - e[1]);
					d1    = (DW+1)'(e[2] + e[6]);
					d2    = (DW+1)'(e[5] + e[7]);
				end
			endcase
		end
		sq_in.v     = '0;
		sq_in.v[VW-1 -: RW+FB] = (rad < 0) ? '0 : {rad[RW-1:0], {FB{1'b0}}};
		sq_in.rem   = '0;
		sq_in.root  = '0;
		sq_in.dslot = dslot;
		sq_in.d     = {d2, d1, d0};
	end

	// ---------------- square root, one root bit per stage
	sq_t  sq_s   [0:RTW];
	logic sq_vld_s [0:RTW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld_s[0] <= 1'b0;
		end else if (en) begin
			sq_vld_s[0] <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			sq_s[0] <= sq_in;
	end

	for (genvar t = 0; t < RTW; t++) begin : g_sqrt
		sq_t nxt;
		always_comb begin
			logic [RTW+1:0] r2, trial;
			r2    = {sq_s[t].rem[RTW-1:0], sq_s[t].v[VW-1 -: 2]};
			trial = {sq_s[t].root, 2'b01};
			nxt   = sq_s[t];
			nxt.v = {sq_s[t].v[VW-3:0], 2'b00};
			if (r2 >= trial) begin
				nxt.rem  = r2 - trial;
				nxt.root = {sq_s[t].root[RTW-2:0], 1'b1};
			end else begin
				nxt.rem  = r2;
				nxt.root = {sq_s[t].root[RTW-2:0], 1'b0};
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[t+1] <= 1'b0;
			end else if (en) begin
				sq_vld_s[t+1] <= sq_vld_s[t];
			end
		end
		always_ff @(posedge clk) begin
			if (en)
				sq_s[t+1] <= nxt;
		end
	end

	// ---------------- divider setup: magnitudes, rounding offset of s/2 = root
	dv_t  dv_s   [0:NW];
	logic dv_vld_s [0:NW];
	dv_t  dv_in;

	always_comb begin
		logic signed [DW:0] dd;
		logic [MW-1:0] mag;
		dv_in.root  = sq_s[RTW].root;
		dv_in.dslot = sq_s[RTW].dslot;
		dv_in.rem   = '0;
		for (int k = 0; k < 3; k++) begin
			dd = $signed(sq_s[RTW].d[k]);
			dv_in.neg[k] = dd[DW];
			mag = dd[DW] ? MW'(-dd) : MW'(dd);
			dv_in.nq[k] = NW'({mag, {FB{1'b0}}}) + NW'(sq_s[RTW].root);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s[0] <= 1'b0;
		end else if (en) begin
			dv_vld_s[0] <= sq_vld_s[RTW];
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			dv_s[0] <= dv_in;
	end

	// ---------------- three restoring dividers, one quotient bit per stage
	for (genvar t = 0; t < NW; t++) begin : g_div
		dv_t nxt;
		always_comb begin
			logic [SW:0]   r2;
			logic [SW-1:0] s;
			logic          ge;
			nxt = dv_s[t];
			s   = {dv_s[t].root, 1'b0};
			for (int k = 0; k < 3; k++) begin
				r2 = {dv_s[t].rem[k], dv_s[t].nq[k][NW-1]};
				ge = (r2 >= {1'b0, s});
				nxt.rem[k] = ge ? SW'(r2 - {1'b0, s}) : SW'(r2);
				nxt.nq[k]  = {dv_s[t].nq[k][NW-2:0], ge};
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[t+1] <= 1'b0;
			end else if (en) begin
				dv_vld_s[t+1] <= dv_vld_s[t];
			end
		end
		always_ff @(posedge clk) begin
			if (en)
				dv_s[t+1] <= nxt;
		end
	end

	// ---------------- output: saturate, place components, register
	function automatic logic [DW-1:0] sat(input logic [NW-1:0] mag, input logic neg);
		logic [NW-1:0] hi, tmp;
		hi  = {{(NW-DW+1){1'b0}}, {(DW-1){1'b1}}};
		tmp = ~mag + NW'(1);
		if (!neg)
			return (mag > hi) ? hi[DW-1:0] : mag[DW-1:0];
		else
			return (mag > hi + NW'(1)) ? {1'b1, {(DW-1){1'b0}}} : tmp[DW-1:0];
	endfunction

	logic [3:0][DW-1:0] q;
	logic               degen;

	always_comb begin
		logic [DW-1:0] diag;
		logic [2:0][DW-1:0] quo;
		diag = sat(NW'(({1'b0, dv_s[NW].root} + (RTW+1)'(1)) >> 1), 1'b0);
		for (int k = 0; k < 3; k++)
			quo[k] = sat(dv_s[NW].nq[k], dv_s[NW].neg[k]);
		degen = (dv_s[NW].root == '0);
		unique case (rmq_pkg::slot_t'(dv_s[NW].dslot))
			rmq_pkg::SLOT_W: q = {quo[2], quo[1], quo[0], diag};
			rmq_pkg::SLOT_X: q = {quo[2], quo[1], diag, quo[0]};
			rmq_pkg::SLOT_Y: q = {quo[2], diag, quo[1], quo[0]};
			default:         q = {diag, quo[2], quo[1], quo[0]};
		endcase
		if (degen)
			q = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= dv_vld_s[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= OUT_W'(q);
			m_axis_tuser <= rmq_pkg::OUT_USER_W'(degen);
		end
	end

endmodule

FILE: hw/rtl/rmq_checker.sv
// port level checks for rotation_matrix_to_quaternion, bound to the top level
// depends on rmq_pkg and the top level's port list
module rmq_checker #(
	parameter int DATA_WIDTH = 16
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic [((9*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [((4*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	input logic [rmq_pkg::OUT_USER_W-1:0] m_axis_tuser
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("stalled result changed");

	// a degenerate item carries all zero components
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[4*DATA_WIDTH-1:0] == '0)
		else $error("degenerate result not zero");

	// the input only stalls when a result waits
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready || !m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled without a waiting result");

	// a waiting result keeps the input stalled
	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while pipeline held");

endmodule

bind rotation_matrix_to_quaternion rmq_checker #(.DATA_WIDTH(DATA_WIDTH)) u_rmq_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tdata(s_axis_tdata),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser)
);
